### src/rcfsd_pkg.sv
package rcfsd_pkg;

    // Frame delimiters
    localparam logic [7:0] HEADER_BYTE  = 8'hFE;
    localparam logic [7:0] TRAILER_BYTE = 8'hFA;

    // Register reset values
    localparam logic [7:0] HOLD_LIMIT_RST = 8'd80;
    localparam logic [7:0] LOW_THRESH_RST = 8'h3A;
    localparam logic [7:0] HIGH_THRESH_RST = 8'hBA;

    // Register map, word index
    typedef enum logic [1:0] {
        REG_HOLD_LIMIT  = 2'd0,
        REG_LOW_THRESH  = 2'd1,
        REG_HIGH_THRESH = 2'd2
    } reg_idx_t;

    localparam int PULSE_W = 11;
    localparam int NUM_LANES = 4;

    // Lane order: throttle, yaw, pitch, roll
    localparam int LANE_THROTTLE = 0;
    localparam int LANE_YAW      = 1;
    localparam int LANE_PITCH    = 2;
    localparam int LANE_ROLL     = 3;

    // Division by 235 as multiply by reciprocal and shift; exact for
    // numerators below 2^18 (error term 86 * 2^18 < 2^26).
    localparam int RECIP_SHIFT = 26;
    localparam longint RECIP = 285570;
    localparam int PROD_W = 36;

    // Each mapping rewritten as floor((u*m + b)/235) + c, u = x or 255-x,
    // with b in 0..234 so the numerator stays non-negative.
    localparam longint MUL_800 = 800 * RECIP;
    localparam longint MUL_600 = 600 * RECIP;
    localparam longint BIAS_225 = 225 * RECIP;
    localparam longint BIAS_110 = 110 * RECIP;

    typedef struct packed {
        logic                invert;
        logic [PROD_W-1:0]   mult;
        logic [PROD_W-1:0]   bias;
        logic [PULSE_W-1:0]  base;
    } lane_const_t;

    localparam lane_const_t LANE_CONST [NUM_LANES] = '{
        '{1'b0, PROD_W'(MUL_800), PROD_W'(BIAS_225), PULSE_W'(1065)},
        '{1'b1, PROD_W'(MUL_800), PROD_W'(BIAS_225), PULSE_W'(1065)},
        '{1'b1, PROD_W'(MUL_600), PROD_W'(BIAS_110), PULSE_W'(1174)},
        '{1'b0, PROD_W'(MUL_600), PROD_W'(BIAS_110), PULSE_W'(1174)}
    };

    // Live configuration
    typedef struct packed {
        logic [7:0] hold_limit;
        logic [7:0] low_thresh;
        logic [7:0] high_thresh;
    } cfg_t;

    // Gesture request pulses for the current frame
    typedef struct packed {
        logic cal;
        logic arm;
    } gest_t;

endpackage

### src/rcfsd_regs.sv
module rcfsd_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rcfsd_pkg::cfg_t     cfg
);

    rcfsd_pkg::cfg_t cfg_reg;
    rcfsd_pkg::cfg_t cfg_next;
    logic            wr_en;
    logic [1:0]      idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                rcfsd_pkg::REG_HOLD_LIMIT:  cfg_next.hold_limit  = pwdata[7:0];
                rcfsd_pkg::REG_LOW_THRESH:  cfg_next.low_thresh  = pwdata[7:0];
                rcfsd_pkg::REG_HIGH_THRESH: cfg_next.high_thresh = pwdata[7:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_limit  <= rcfsd_pkg::HOLD_LIMIT_RST;
            cfg_reg.low_thresh  <= rcfsd_pkg::LOW_THRESH_RST;
            cfg_reg.high_thresh <= rcfsd_pkg::HIGH_THRESH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        case (idx)
            rcfsd_pkg::REG_HOLD_LIMIT:  prdata = {24'd0, cfg_reg.hold_limit};
            rcfsd_pkg::REG_LOW_THRESH:  prdata = {24'd0, cfg_reg.low_thresh};
            rcfsd_pkg::REG_HIGH_THRESH: prdata = {24'd0, cfg_reg.high_thresh};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### src/rcfsd_lane.sv
module rcfsd_lane (
    input  logic [7:0]                         stick,
    input  rcfsd_pkg::lane_const_t             lane_const,
    output logic [rcfsd_pkg::PULSE_W-1:0]      pulse
);

    logic [7:0]                   u;
    logic [rcfsd_pkg::PROD_W-1:0] prod;
    logic [rcfsd_pkg::PROD_W-1:0] sum;
    logic [rcfsd_pkg::PROD_W-rcfsd_pkg::RECIP_SHIFT-1:0] quot;

    // Falling ranges run on 255 - x so the numerator stays positive
    assign u    = lane_const.invert ? ~stick : stick;
    assign prod = rcfsd_pkg::PROD_W'(u) * lane_const.mult;
    assign sum  = prod + lane_const.bias;
    assign quot = sum[rcfsd_pkg::PROD_W-1:rcfsd_pkg::RECIP_SHIFT];
    assign pulse = rcfsd_pkg::PULSE_W'(quot) + lane_const.base;

endmodule

### src/rcfsd_gesture.sv
module rcfsd_gesture (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             frame_en,
    input  logic [7:0]       throttle,
    input  logic [7:0]       yaw,
    input  rcfsd_pkg::cfg_t  cfg,
    output rcfsd_pkg::gest_t gest
);

    logic [7:0] cal_cnt_reg;
    logic [7:0] cal_cnt_next;
    logic [7:0] arm_cnt_reg;
    logic [7:0] arm_cnt_next;
    logic [7:0] cal_inc;
    logic [7:0] arm_inc;
    logic       thr_low;
    logic       cal_hold;
    logic       arm_hold;

    assign thr_low  = throttle < cfg.low_thresh;
    assign cal_hold = thr_low && (yaw < cfg.low_thresh);
    assign arm_hold = thr_low && (yaw > cfg.high_thresh) && !cal_hold;
    assign cal_inc  = cal_cnt_reg + 8'd1;
    assign arm_inc  = arm_cnt_reg + 8'd1;

    // Hold counters; pulse and restart once the limit is exceeded
    always_comb begin
        cal_cnt_next = cal_cnt_reg;
        arm_cnt_next = arm_cnt_reg;
        gest.cal     = 1'b0;
        gest.arm     = 1'b0;
        if (frame_en) begin
            if (cal_hold) begin
                if (cal_inc > cfg.hold_limit) begin
                    cal_cnt_next = 8'd0;
                    gest.cal     = 1'b1;
                end else begin
                    cal_cnt_next = cal_inc;
                end
            end else if (arm_hold) begin
                if (arm_inc > cfg.hold_limit) begin
                    arm_cnt_next = 8'd0;
                    gest.arm     = 1'b1;
                end else begin
                    arm_cnt_next = arm_inc;
                end
            end else begin
                cal_cnt_next = 8'd0;
                arm_cnt_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_cnt_reg <= 8'd0;
            arm_cnt_reg <= 8'd0;
        end else begin
            cal_cnt_reg <= cal_cnt_next;
            arm_cnt_reg <= arm_cnt_next;
        end
    end

endmodule

### src/rc_frame_stick_decoder.sv
// RC frame stick decoder.
// Input stream (s_*): one transfer per received frame carrying header, four
// stick bytes and trailer. Output stream (m_*): one transfer per input
// transfer with the held pulse widths, the gesture request flags and, in
// m_tuser, frame_ok.
// A frame with header 0xFE and trailer 0xFA updates the four pulse values
// through four parallel scaling lanes (constant reciprocal multiply) and
// advances the calibrate/arm hold counters; other frames leave them as held.
// The result is registered at the edge the frame is accepted. Throughput is
// one frame per cycle while m_tready keeps up; the single output register
// is refilled in the same cycle it drains, so s_tready = !m_tvalid | m_tready.
// If the receiver stalls, the result holds and s_tready drops until taken.
// Reset (aresetn low, synchronous) clears pulses and counters to zero,
// empties the output register and restores the registers to 80, 0x3A, 0xBA.
// APB registers: 0x0 hold limit, 0x4 low threshold, 0x8 high threshold.
module rc_frame_stick_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Frame input
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] header_byte, [15:8] pitch_byte, [23:16] roll_byte,
    // [31:24] throttle_byte, [39:32] yaw_byte, [47:40] trailer_byte
    input  logic [47:0] s_tdata,
    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] throttle_pulse, [21:11] yaw_pulse, [32:22] pitch_pulse,
    // [43:33] roll_pulse, [44] calibrate_request, [45] arm_request, [47:46] 0
    output logic [47:0] m_tdata,
    // [0] frame_ok
    output logic        m_tuser
);

    rcfsd_pkg::cfg_t  cfg;
    rcfsd_pkg::gest_t gest;

    logic [7:0] header_byte;
    logic [7:0] pitch_byte;
    logic [7:0] roll_byte;
    logic [7:0] throttle_byte;
    logic [7:0] yaw_byte;
    logic [7:0] trailer_byte;
    logic       s_xfer;
    logic       frame_ok;
    logic       frame_en;

    logic [7:0]                  lane_in  [rcfsd_pkg::NUM_LANES];
    logic [rcfsd_pkg::PULSE_W-1:0] lane_out [rcfsd_pkg::NUM_LANES];

    logic [rcfsd_pkg::PULSE_W-1:0] pulse_reg [rcfsd_pkg::NUM_LANES];
    logic                          m_valid_reg;
    logic                          ok_reg;
    logic                          cal_reg;
    logic                          arm_reg;

    assign header_byte   = s_tdata[7:0];
    assign pitch_byte    = s_tdata[15:8];
    assign roll_byte     = s_tdata[23:16];
    assign throttle_byte = s_tdata[31:24];
    assign yaw_byte      = s_tdata[39:32];
    assign trailer_byte  = s_tdata[47:40];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign frame_ok = (header_byte == rcfsd_pkg::HEADER_BYTE) &&
                      (trailer_byte == rcfsd_pkg::TRAILER_BYTE);
    assign frame_en = s_xfer && frame_ok;

    // Configuration registers
    rcfsd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Scaling lanes
    assign lane_in[rcfsd_pkg::LANE_THROTTLE] = throttle_byte;
    assign lane_in[rcfsd_pkg::LANE_YAW]      = yaw_byte;
    assign lane_in[rcfsd_pkg::LANE_PITCH]    = pitch_byte;
    assign lane_in[rcfsd_pkg::LANE_ROLL]     = roll_byte;

    for (genvar i = 0; i < rcfsd_pkg::NUM_LANES; i++) begin : g_lane
        rcfsd_lane u_lane (
            .stick      (lane_in[i]),
            .lane_const (rcfsd_pkg::LANE_CONST[i]),
            .pulse      (lane_out[i])
        );
    end

    // Gesture counters
    rcfsd_gesture u_gesture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .frame_en (frame_en),
        .throttle (throttle_byte),
        .yaw      (yaw_byte),
        .cfg      (cfg),
        .gest     (gest)
    );

    // Merge stage: held pulses double as the output payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rcfsd_pkg::NUM_LANES; i++) begin
                pulse_reg[i] <= '0;
            end
        end else if (frame_en) begin
            for (int i = 0; i < rcfsd_pkg::NUM_LANES; i++) begin
                pulse_reg[i] <= lane_out[i];
            end
        end
    end

    // Output register flags and valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ok_reg      <= 1'b0;
            cal_reg     <= 1'b0;
            arm_reg     <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
            ok_reg      <= frame_ok;
            cal_reg     <= gest.cal;
            arm_reg     <= gest.arm;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {2'b00, arm_reg, cal_reg,
                       pulse_reg[rcfsd_pkg::LANE_ROLL],
                       pulse_reg[rcfsd_pkg::LANE_PITCH],
                       pulse_reg[rcfsd_pkg::LANE_YAW],
                       pulse_reg[rcfsd_pkg::LANE_THROTTLE]};

    // Checks
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[44] && m_tdata[45]))
        else $error("calibrate and arm requested together");

    a_req_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (!m_tdata[44] && !m_tdata[45]))
        else $error("request raised on a rejected frame");

    a_payload_only_on_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_xfer |=> $stable(m_tdata))
        else $error("result payload changed without an input transfer");

endmodule
